### rtl/tetrahedron_barycentric_coords_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tetrahedron barycentric block
// Concurrent checks that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef TETRAHEDRON_BARYCENTRIC_COORDS_DEFINES_SVH
`define TETRAHEDRON_BARYCENTRIC_COORDS_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define TBC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define TBC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TBC_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define TBC_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/tbc_pkg.sv
// ----------------------------------------------------------------------------
// tbc_pkg
// Shared types and constants of the tetrahedron barycentric block.
// ----------------------------------------------------------------------------
package tbc_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_QUERY_X = 2'd0,
    REG_QUERY_Y = 2'd1,
    REG_QUERY_Z = 2'd2
  } cfg_reg_t;

  localparam int CFG_IDX_W  = 2;
  // Register stages inside one orientation determinant unit.
  localparam int ORIENT_LAT = 6;
  // Quotient bits produced by the divider, one per stage.
  localparam int QUO_BITS   = 32;
  localparam int WEIGHT_W   = 32;
  localparam int LANES      = 4;

  localparam logic [WEIGHT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [WEIGHT_W-1:0] SAT_NEG = 32'h8000_0000;

  // Per-lane flags that travel with the divider.
  typedef struct packed {
    logic neg;
    logic zero;
    logic big;
  } lane_flag_t;

endpackage

### rtl/tbc_orient.sv
// ----------------------------------------------------------------------------
// tbc_orient
// Pipelined exact 3x3 determinant det(b-a, c-a, d-a) in six stages.
// ----------------------------------------------------------------------------
module tbc_orient #(
  parameter int COORD_BITS = 24
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [COORD_BITS-1:0]   a [3],
  input  logic signed [COORD_BITS-1:0]   b [3],
  input  logic signed [COORD_BITS-1:0]   c [3],
  input  logic signed [COORD_BITS-1:0]   d [3],
  output logic signed [3*(COORD_BITS+1)+2:0] det
);

  localparam int DW_ = COORD_BITS + 1;          // edge vector width
  localparam int PW  = 2 * DW_;                 // product width
  localparam int MW  = 2 * DW_ + 1;             // minor width
  localparam int LW  = (MW + 1) / 2;            // low slice of a minor
  localparam int HW  = MW - LW;                 // high slice of a minor
  localparam int RW  = 3 * DW_ + 3;             // determinant width

  logic signed [DW_-1:0]  u1 [3], v1 [3], t1 [3];
  logic signed [DW_-1:0]  u2 [3], u3 [3];
  logic signed [PW-1:0]   pr [6];
  logic signed [MW-1:0]   mn [3];
  logic signed [DW_+LW:0] lo [3];
  logic signed [DW_+HW-1:0] hi [3];
  logic signed [RW-1:0]   pp [3];

  // Stage 1: edge vectors from the first point.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        u1[j] <= $signed({b[j][COORD_BITS-1], b[j]}) - $signed({a[j][COORD_BITS-1], a[j]});
        v1[j] <= $signed({c[j][COORD_BITS-1], c[j]}) - $signed({a[j][COORD_BITS-1], a[j]});
        t1[j] <= $signed({d[j][COORD_BITS-1], d[j]}) - $signed({a[j][COORD_BITS-1], a[j]});
      end
    end
  end

  // Stage 2: the six products of the 2x2 minors.
  always_ff @(posedge clk) begin
    if (en) begin
      pr[0] <= v1[1] * t1[2];
      pr[1] <= v1[2] * t1[1];
      pr[2] <= v1[0] * t1[2];
      pr[3] <= v1[2] * t1[0];
      pr[4] <= v1[0] * t1[1];
      pr[5] <= v1[1] * t1[0];
      u2    <= u1;
    end
  end

  // Stage 3: the three minors.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mn[k] <= MW'(pr[2*k]) - MW'(pr[2*k+1]);
      end
      u3 <= u2;
    end
  end

  // Stage 4: each edge term times a minor, split in two partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        lo[k] <= u3[k] * $signed({1'b0, mn[k][LW-1:0]});
        hi[k] <= u3[k] * $signed(mn[k][MW-1:LW]);
      end
    end
  end

  // Stage 5: recombine the partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pp[k] <= (RW'(hi[k]) <<< LW) + RW'(lo[k]);
      end
    end
  end

  // Stage 6: cofactor expansion along the first edge.
  always_ff @(posedge clk) begin
    if (en) begin
      det <= pp[0] - pp[1] + pp[2];
    end
  end

endmodule

### rtl/tetrahedron_barycentric_coords.sv
// ----------------------------------------------------------------------------
// tetrahedron_barycentric_coords
// Barycentric coordinates of a query point in a stream of tetrahedra.
// ----------------------------------------------------------------------------
// The block accepts one tetrahedron per clock unless a result is held at a
// stalled output, and returns its four Q8.24 weights, the inside flag and
// the degenerate flag through six stages for the exact determinants, two for
// sign and range checks, one per quotient bit in the 32-stage restoring
// divider, and the output register. The query point comes from three
// configuration registers (origin after reset) and must only be written
// while no item is in flight. A held result holds the whole pipeline.
// ----------------------------------------------------------------------------
`include "tetrahedron_barycentric_coords_defines.svh"

module tetrahedron_barycentric_coords #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tbc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [COORD_BITS-1:0]             cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COORD_BITS-1:0]      v0_x,
  input  logic signed [COORD_BITS-1:0]      v0_y,
  input  logic signed [COORD_BITS-1:0]      v0_z,
  input  logic signed [COORD_BITS-1:0]      v1_x,
  input  logic signed [COORD_BITS-1:0]      v1_y,
  input  logic signed [COORD_BITS-1:0]      v1_z,
  input  logic signed [COORD_BITS-1:0]      v2_x,
  input  logic signed [COORD_BITS-1:0]      v2_y,
  input  logic signed [COORD_BITS-1:0]      v2_z,
  input  logic signed [COORD_BITS-1:0]      v3_x,
  input  logic signed [COORD_BITS-1:0]      v3_y,
  input  logic signed [COORD_BITS-1:0]      v3_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [tbc_pkg::WEIGHT_W-1:0] weight_0,
  output logic signed [tbc_pkg::WEIGHT_W-1:0] weight_1,
  output logic signed [tbc_pkg::WEIGHT_W-1:0] weight_2,
  output logic signed [tbc_pkg::WEIGHT_W-1:0] weight_3,
  output logic                              inside_res,
  output logic                              degenerate
);

  localparam int DW   = 3 * (COORD_BITS + 1) + 3;     // determinant width
  localparam int QB   = tbc_pkg::QUO_BITS;
  localparam int RW   = DW + QB;                      // remainder width
  localparam int NL   = tbc_pkg::LANES;
  localparam int LAT  = tbc_pkg::ORIENT_LAT + 2 + QB + 1;
  localparam int BIGS = QB - FRAC_BITS;

  logic signed [COORD_BITS-1:0] query_x, query_y, query_z;
  logic [LAT-1:0]               vld;
  logic                         en;

  logic signed [COORD_BITS-1:0] pa [5][3];
  logic signed [COORD_BITS-1:0] pb [5][3];
  logic signed [COORD_BITS-1:0] pc [5][3];
  logic signed [COORD_BITS-1:0] pd [5][3];
  logic signed [DW-1:0]         det [5];

  // Sign and magnitude stage.
  logic [DW-1:0]        den_abs;
  logic                 den_zero;
  logic                 den_neg;
  logic [DW-1:0]        num_abs [NL];
  logic                 num_neg [NL];
  logic                 num_zero [NL];

  // Divider pipeline, entry 0 is loaded by the range check stage.
  logic [RW-1:0]           rem [QB+1][NL];
  logic [QB-1:0]           quo [QB+1][NL];
  tbc_pkg::lane_flag_t     lf  [QB+1][NL];
  logic [DW-1:0]           dvs [QB+1];
  logic                    deg_p [QB+1];
  logic                    ins_p [QB+1];

  logic signed [tbc_pkg::WEIGHT_W-1:0] wt [NL];

  // The pipeline moves unless a finished item waits at a stalled output.
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[LAT-1];

  // Query point registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      query_x <= '0;
      query_y <= '0;
      query_z <= '0;
    end else if (cfg_we) begin
      unique case (tbc_pkg::cfg_reg_t'(cfg_index))
        tbc_pkg::REG_QUERY_X: query_x <= cfg_data;
        tbc_pkg::REG_QUERY_Y: query_y <= cfg_data;
        tbc_pkg::REG_QUERY_Z: query_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // Point sets for the full determinant and the four with the query point.
  always_comb begin
    logic signed [COORD_BITS-1:0] vt [4][3];
    logic signed [COORD_BITS-1:0] qp [3];
    vt[0] = '{v0_x, v0_y, v0_z};
    vt[1] = '{v1_x, v1_y, v1_z};
    vt[2] = '{v2_x, v2_y, v2_z};
    vt[3] = '{v3_x, v3_y, v3_z};
    qp    = '{query_x, query_y, query_z};
    pa[0] = vt[0]; pb[0] = vt[1]; pc[0] = vt[2]; pd[0] = vt[3];
    pa[1] = qp;    pb[1] = vt[1]; pc[1] = vt[2]; pd[1] = vt[3];
    pa[2] = vt[0]; pb[2] = qp;    pc[2] = vt[2]; pd[2] = vt[3];
    pa[3] = vt[0]; pb[3] = vt[1]; pc[3] = qp;    pd[3] = vt[3];
    pa[4] = vt[0]; pb[4] = vt[1]; pc[4] = vt[2]; pd[4] = qp;
  end

  for (genvar g = 0; g < 5; g++) begin : g_orient
    tbc_orient #(
      .COORD_BITS(COORD_BITS)
    ) u_orient (
      .clk(clk),
      .en (en),
      .a  (pa[g]),
      .b  (pb[g]),
      .c  (pc[g]),
      .d  (pd[g]),
      .det(det[g])
    );
  end

  // Magnitudes and signs of the determinants.
  always_ff @(posedge clk) begin
    if (en) begin
      den_neg  <= det[0][DW-1];
      den_zero <= (det[0] == '0);
      den_abs  <= det[0][DW-1] ? DW'(-det[0]) : DW'(det[0]);
      for (int i = 0; i < NL; i++) begin
        num_neg[i]  <= det[i+1][DW-1];
        num_zero[i] <= (det[i+1] == '0);
        num_abs[i]  <= det[i+1][DW-1] ? DW'(-det[i+1]) : DW'(det[i+1]);
      end
    end
  end

  // Range checks and divider load, then the restoring divider: one quotient
  // bit per stage, most significant first.
  always_ff @(posedge clk) begin
    logic          ins;
    logic [RW-1:0] dsh;
    if (en) begin
      ins = 1'b1;
      for (int i = 0; i < NL; i++) begin
        if (!num_zero[i] && ((num_neg[i] != den_neg) || (num_abs[i] > den_abs))) begin
          ins = 1'b0;
        end
        rem[0][i]      <= RW'(num_abs[i]) << FRAC_BITS;
        quo[0][i]      <= '0;
        lf[0][i].neg   <= num_neg[i] != den_neg;
        lf[0][i].zero  <= num_zero[i];
        lf[0][i].big   <= RW'(num_abs[i]) >= (RW'(den_abs) << BIGS);
      end
      dvs[0]   <= den_abs;
      deg_p[0] <= den_zero;
      ins_p[0] <= ins && !den_zero;

      for (int s = 0; s < QB; s++) begin
        dsh = RW'(dvs[s]) << (QB - 1 - s);
        for (int i = 0; i < NL; i++) begin
          if (rem[s][i] >= dsh) begin
            rem[s+1][i] <= rem[s][i] - dsh;
            quo[s+1][i] <= {quo[s][i][QB-2:0], 1'b1};
          end else begin
            rem[s+1][i] <= rem[s][i];
            quo[s+1][i] <= {quo[s][i][QB-2:0], 1'b0};
          end
          lf[s+1][i] <= lf[s][i];
        end
        dvs[s+1]   <= dvs[s];
        deg_p[s+1] <= deg_p[s];
        ins_p[s+1] <= ins_p[s];
      end
    end
  end

  // Output register: sign, saturation, and the zero and degenerate cases.
  always_ff @(posedge clk) begin
    logic [QB-1:0] m;
    if (en) begin
      for (int i = 0; i < NL; i++) begin
        m = quo[QB][i];
        if (deg_p[QB] || lf[QB][i].zero) begin
          wt[i] <= '0;
        end else if (lf[QB][i].neg) begin
          if (lf[QB][i].big || (m > tbc_pkg::SAT_NEG)) begin
            m = tbc_pkg::SAT_NEG;
          end
          wt[i] <= $signed(~m + 1'b1);
        end else begin
          if (lf[QB][i].big || m[QB-1]) begin
            m = tbc_pkg::SAT_POS;
          end
          wt[i] <= $signed(m);
        end
      end
      inside_res <= ins_p[QB];
      degenerate <= deg_p[QB];
    end
  end

  assign weight_0 = wt[0];
  assign weight_1 = wt[1];
  assign weight_2 = wt[2];
  assign weight_3 = wt[3];

  // A flat tetrahedron gives zero weights and is never inside.
  `TBC_ASSERT_IMP(a_degenerate_zero, clk, rst, out_valid && degenerate,
    weight_0 == 0 && weight_1 == 0 && weight_2 == 0 && weight_3 == 0 && !inside_res,
    "degenerate item with nonzero result")

  // An inside point has every weight between zero and one.
  `TBC_ASSERT_IMP(a_inside_range, clk, rst, out_valid && inside_res,
    !weight_0[31] && !weight_1[31] && !weight_2[31] && !weight_3[31] &&
    weight_0 <= (1 <<< FRAC_BITS) && weight_1 <= (1 <<< FRAC_BITS) &&
    weight_2 <= (1 <<< FRAC_BITS) && weight_3 <= (1 <<< FRAC_BITS),
    "inside item with weight outside zero to one")

  // A held result keeps the whole pipeline frozen for the next cycle.
  `TBC_ASSERT_NXT(a_hold_pipe, clk, rst, out_valid && out_stall,
    $stable(vld) && $stable(wt[0]) && $stable(ins_p[0]),
    "pipeline moved while the output was stalled")

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for tetrahedron_barycentric_coords
// Streams tetrahedra through the block under several query points and checks
// every weight and flag against exact barycentric arithmetic done here.
// ----------------------------------------------------------------------------
typedef logic signed [23:0]  coord_t;
typedef logic signed [191:0] exact_t;
typedef longint              point_t [3];

typedef struct {
  coord_t v [4][3];
} tetra_t;

typedef struct {
  logic signed [31:0] w [4];
  bit                 in_unit;
  bit                 degen;
} weights_t;

// Holds the query point and the weights still owed by the block.
class weight_board;
  weights_t owed [$];
  coord_t   query [3];
  int       errors, checked, degens, insides;

  function new();
    query = '{default: '0};
  endfunction

  function void set_query(int idx, coord_t val);
    if (idx < 3) query[idx] = val;
  endfunction

  function int pending();
    return owed.size();
  endfunction

  // Signed volume of (b-a, c-a, d-a), exact.
  static function exact_t orient(point_t a, point_t b, point_t c, point_t d);
    exact_t u [3];
    exact_t s [3];
    exact_t t [3];
    exact_t m0, m1, m2;
    for (int i = 0; i < 3; i++) begin
      u[i] = b[i] - a[i];
      s[i] = c[i] - a[i];
      t[i] = d[i] - a[i];
    end
    m0 = s[1] * t[2] - s[2] * t[1];
    m1 = s[0] * t[2] - s[2] * t[0];
    m2 = s[0] * t[1] - s[1] * t[0];
    return u[0] * m0 - u[1] * m1 + u[2] * m2;
  endfunction

  // Quotient num/den in Q8.24, truncated toward zero and saturated.
  static function logic signed [31:0] to_q824(exact_t num, exact_t den);
    logic [191:0] mn, md, q;
    bit           neg;
    if (num == 0) return '0;
    neg = (num < 0) != (den < 0);
    mn  = (num < 0) ? -num : num;
    md  = (den < 0) ? -den : den;
    q   = (mn << 24) / md;
    if (neg) begin
      if (q > 192'h8000_0000) q = 192'h8000_0000;
      return -q[31:0];
    end
    if (q > 192'h7FFF_FFFF) q = 192'h7FFF_FFFF;
    return q[31:0];
  endfunction

  // Computes the expected weights of one accepted tetrahedron.
  function void note_item(tetra_t tt);
    point_t   p [4];
    point_t   qp;
    exact_t   full, part;
    weights_t r;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 3; j++) p[i][j] = tt.v[i][j];
    for (int j = 0; j < 3; j++) qp[j] = query[j];
    r.in_unit = 1;
    r.degen   = 0;
    full = orient(p[0], p[1], p[2], p[3]);
    if (full == 0) begin
      r.w = '{default: '0};
      r.in_unit = 0;
      r.degen   = 1;
    end else begin
      for (int i = 0; i < 4; i++) begin
        point_t s [4];
        s = p;
        s[i] = qp;
        part = orient(s[0], s[1], s[2], s[3]);
        r.w[i] = to_q824(part, full);
        // The point lies in the closed unit range only with matching signs.
        if (part != 0 && (((part < 0) != (full < 0)) ||
            ((part < 0 ? -part : part) > (full < 0 ? -full : full))))
          r.in_unit = 0;
      end
    end
    owed = {owed, r};
  endfunction

  function void check_result(weights_t act);
    weights_t e;
    bit       bad;
    if (owed.size() == 0) begin
      errors++;
      if (errors <= 10) $display("Result with no item outstanding: w0=%h", act.w[0]);
      return;
    end
    e = owed.pop_front();
    checked++;
    degens  += e.degen;
    insides += e.in_unit;
    bad = (e.in_unit != act.in_unit) || (e.degen != act.degen);
    for (int i = 0; i < 4; i++) if (e.w[i] !== act.w[i]) bad = 1;
    if (bad) begin
      errors++;
      if (errors <= 10)
        $display({"Mismatch on item %0d: exp w=%h %h %h %h in=%0d dg=%0d,",
                  " got w=%h %h %h %h in=%0d dg=%0d"},
                 checked - 1, e.w[0], e.w[1], e.w[2], e.w[3], e.in_unit, e.degen,
                 act.w[0], act.w[1], act.w[2], act.w[3], act.in_unit, act.degen);
    end
  endfunction
endclass

module tb;

  localparam logic [tbc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT  = 5000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [tbc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  coord_t v0_x = 0, v0_y = 0, v0_z = 0, v1_x = 0, v1_y = 0, v1_z = 0;
  coord_t v2_x = 0, v2_y = 0, v2_z = 0, v3_x = 0, v3_y = 0, v3_z = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] weight_0, weight_1, weight_2, weight_3;
  logic inside_res, degenerate;

  weight_board board = new();
  bit calm = 0;
  int idle_cycles = 0;
  int queries = 1;

  tetrahedron_barycentric_coords dut (.*);

  always #5 clk = ~clk;

  // Receiver stalls now and then, except during the calm stretch.
  always @(posedge clk) out_stall <= !calm && ($urandom_range(0, 99) < 7);

  // Sample both handshakes and watch for a hung pipeline.
  always @(posedge clk) begin
    if (!rst) begin
      tetra_t   tt;
      weights_t act;
      bit       moved;
      moved = 0;
      if (in_valid && !in_stall) begin
        tt.v = '{'{v0_x, v0_y, v0_z}, '{v1_x, v1_y, v1_z},
                 '{v2_x, v2_y, v2_z}, '{v3_x, v3_y, v3_z}};
        board.note_item(tt);
        moved = 1;
      end
      if (out_valid && !out_stall) begin
        act.w = '{weight_0, weight_1, weight_2, weight_3};
        act.in_unit = inside_res;
        act.degen   = degenerate;
        board.check_result(act);
        moved = 1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Writes one register once the pipeline has emptied.
  task automatic write_reg(logic [tbc_pkg::CFG_IDX_W-1:0] idx, coord_t val);
    while (board.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 0;
    board.set_query(idx, val);
  endtask

  task automatic set_point(coord_t x, coord_t y, coord_t z);
    write_reg(tbc_pkg::REG_QUERY_X, x);
    write_reg(tbc_pkg::REG_QUERY_Y, y);
    write_reg(tbc_pkg::REG_QUERY_Z, z);
    queries++;
  endtask

  // Presents one item and holds it until the block takes it.
  task automatic send(tetra_t tt);
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_valid <= 0;
      @(posedge clk);
    end
    {v0_x, v0_y, v0_z} <= {tt.v[0][0], tt.v[0][1], tt.v[0][2]};
    {v1_x, v1_y, v1_z} <= {tt.v[1][0], tt.v[1][1], tt.v[1][2]};
    {v2_x, v2_y, v2_z} <= {tt.v[2][0], tt.v[2][1], tt.v[2][2]};
    {v3_x, v3_y, v3_z} <= {tt.v[3][0], tt.v[3][1], tt.v[3][2]};
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic tetra_t make(int a0, int a1, int a2, int b0, int b1, int b2,
                                  int c0, int c1, int c2, int d0, int d1, int d2);
    tetra_t tt;
    tt.v = '{'{coord_t'(a0), coord_t'(a1), coord_t'(a2)},
             '{coord_t'(b0), coord_t'(b1), coord_t'(b2)},
             '{coord_t'(c0), coord_t'(c1), coord_t'(c2)},
             '{coord_t'(d0), coord_t'(d1), coord_t'(d2)}};
    return tt;
  endfunction

  // Random tetrahedron: mostly small shapes around the query point, some
  // full-range, some degenerate.
  function automatic tetra_t random_tetra();
    tetra_t tt;
    int     kind, spread;
    kind   = $urandom_range(0, 9);
    spread = (kind < 3) ? 8 : 4000;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 3; j++) begin
        if (kind < 6)
          tt.v[i][j] = coord_t'(board.query[j] + $urandom_range(0, 2 * spread) - spread);
        else if (kind < 8)
          tt.v[i][j] = coord_t'($urandom);
        else
          tt.v[i][j] = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      end
    // Flatten or collapse now and then.
    if ($urandom_range(0, 9) == 0) tt.v[3] = tt.v[$urandom_range(0, 2)];
    if ($urandom_range(0, 9) == 0)
      for (int i = 0; i < 4; i++) tt.v[i][2] = tt.v[0][2];
    return tt;
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed shapes with the query point at the origin.
    send(make(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1));
    send(make(-1, -1, -1, 4, -1, -1, -1, 4, -1, -1, -1, 4));
    send(make(-1, -1, 0, 2, -1, 0, -1, 2, 0, 0, 0, 5));
    send(make(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(make(1, 2, 0, -3, 4, 0, 5, -6, 0, 7, 7, 0));
    send(make(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
              8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
    send(make(-8388608, -8388608, -8388608, 8388607, -8388608, -8388608,
              -8388608, 8388607, -8388608, -8388608, -8388608, 8388607));
    send(make(8388607, 8388607, 8388607, -8388608, 8388607, 8388607,
              8388607, -8388608, 8388607, 8388607, 8388607, -8388608));
    send(make(1000000, 1000000, 1000000, 1000001, 1000000, 1000000,
              1000000, 1000001, 1000000, 1000000, 1000000, 1000001));
    send(make(-5, -5, -5, -4, -5, -5, -5, -4, -5, -5, -5, -4));
    send(make('h555555, 'hAAAAAA, 'h555555, 'hAAAAAA, 'h555555, 'hAAAAAA,
              'h2AAAAA, 'h155555, 'h7FFFFF, 'h000001, 'hFFFFFE, 'h400000));
    send(make(0, 0, 0, 2, 0, 0, 0, 2, 0, 0, 0, 2));
    in_valid <= 0;

    // Extreme query points, plus a write to the unused index.
    set_point(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
    write_reg(REG_SPARE, 24'sh123456);
    send(make(8388607, -8388608, 8388607, 8388606, -8388608, 8388607,
              8388607, -8388607, 8388607, 8388607, -8388608, 8388606));
    send(make(-8388608, -8388608, -8388608, 8388607, -8388608, -8388608,
              -8388608, 8388607, -8388608, -8388608, -8388608, 8388607));
    for (int i = 0; i < 40; i++) send(random_tetra());
    in_valid <= 0;
    set_point(24'sh800000, 24'sh7FFFFF, 24'sh800000);
    for (int i = 0; i < 40; i++) send(random_tetra());
    in_valid <= 0;

    // Random query points and finally the origin, each with a run of random tetrahedra.
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 4) set_point('0, '0, '0);
      else set_point(coord_t'($urandom_range(0, 200) - 100), coord_t'($urandom),
                     coord_t'($urandom_range(0, 2000) - 1000));
      for (int i = 0; i < 110; i++) begin
        calm = (ph == 2);
        send(random_tetra());
      end
      calm = 0;
      in_valid <= 0;
    end

    while (board.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d tetrahedra under %0d query points: %0d degenerate, %0d inside.",
             board.checked, queries, board.degens, board.insides);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", board.errors, board.pending());
      $display("FAILURE");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+rtl
rtl/tbc_pkg.sv
rtl/tbc_orient.sv
rtl/tetrahedron_barycentric_coords.sv
verif/tb.sv
